@@ src/dqu_pkg.sv @@
package dqu_pkg;

    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam logic [VALUE_W-1:0] NO_VALUE = '1;

endpackage

@@ src/dqu_ram.sv @@
module dqu_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/double_ended_queue_unit.sv @@
// Bounded double-ended queue of signed 32-bit values held in a ring of DEPTH entries in a
// single-port-read, single-port-write memory. Each input item (tuser = operation: push front,
// push back, pop front, pop back; tdata = value) gives exactly one result item carrying the
// popped value (all ones for pushes and failed pops), the entry count after the operation and
// a status in tuser (ok, pop on empty, push on full refused). A result passes from the pending
// register, which waits for the memory read, on into the output register; an item can
// be accepted in every cycle as long as results are taken, so the sustained rate is one item
// per cycle. Pointers update when the item is accepted and writes land before any later read,
// so no forwarding is needed. The store needs no clearing pass after reset.
module double_ended_queue_unit #(
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1),
    localparam int OW   = ((dqu_pkg::VALUE_W + CW + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [dqu_pkg::VALUE_W-1:0]  i_s_tdata,   // item_value
    input  logic [dqu_pkg::MODE_W-1:0]   i_s_tuser,   // mode
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [OW-1:0]                o_m_tdata,   // popped_value, count_after, zero pad
    output logic [dqu_pkg::STATUS_W-1:0] o_m_tuser    // status
);

    localparam int SW = AW + 1;

    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    logic                        r_pv;
    logic                        r_pmem;
    dqu_pkg::t_status            r_pstat;
    logic [CW-1:0]               r_pcnt;
    logic                        n_pmem;
    dqu_pkg::t_status            n_pstat;

    logic                        r_ov;
    logic [dqu_pkg::VALUE_W-1:0] r_oval;
    dqu_pkg::t_status            r_ostat;
    logic [CW-1:0]               r_ocnt;

    dqu_pkg::t_mode              mode;
    logic                        accept;
    logic                        move;
    logic                        full;
    logic                        empty;
    logic [SW-1:0]               sum_back;
    logic [SW-1:0]               sum_last;
    logic [AW-1:0]               back_pos;
    logic [AW-1:0]               last_pos;
    logic [AW-1:0]               front_inc;
    logic [AW-1:0]               front_dec;
    logic                        we;
    logic                        re;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr;
    logic [dqu_pkg::VALUE_W-1:0] rdata;

    assign mode       = dqu_pkg::t_mode'(i_s_tuser);
    assign move       = r_pv && (!r_ov || i_m_tready);
    assign o_s_tready = !r_pv || move;
    assign accept     = i_s_tvalid && o_s_tready;

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    // ring positions wrap without a modulo: sums stay below twice the depth
    assign sum_back  = SW'(r_front) + SW'(r_count);
    assign sum_last  = sum_back - SW'(1);
    assign back_pos  = (sum_back >= SW'(DEPTH)) ? AW'(sum_back - SW'(DEPTH)) : AW'(sum_back);
    assign last_pos  = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        n_pmem  = 1'b0;
        n_pstat = dqu_pkg::ST_OK;
        we      = 1'b0;
        re      = 1'b0;
        waddr   = back_pos;
        raddr   = r_front;
        case (mode)
            dqu_pkg::MODE_PUSH_FRONT: begin
                if (full) begin
                    n_pstat = dqu_pkg::ST_FULL;
                end else begin
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                    waddr   = front_dec;
                    we      = accept;
                end
            end
            dqu_pkg::MODE_PUSH_BACK: begin
                if (full) begin
                    n_pstat = dqu_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    waddr   = back_pos;
                    we      = accept;
                end
            end
            dqu_pkg::MODE_POP_FRONT: begin
                if (empty) begin
                    n_pstat = dqu_pkg::ST_EMPTY;
                end else begin
                    n_front = front_inc;
                    n_count = r_count - CW'(1);
                    raddr   = r_front;
                    re      = accept;
                    n_pmem  = 1'b1;
                end
            end
            dqu_pkg::MODE_POP_BACK: begin
                if (empty) begin
                    n_pstat = dqu_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                    raddr   = last_pos;
                    re      = accept;
                    n_pmem  = 1'b1;
                end
            end
            default: begin
                n_pstat = dqu_pkg::ST_OK;
            end
        endcase
    end

    dqu_ram #(
        .DEPTH (DEPTH),
        .WIDTH (dqu_pkg::VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_s_tdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_pv    <= 1'b0;
        end else begin
            if (accept) begin
                r_front <= n_front;
                r_count <= n_count;
                r_pv    <= 1'b1;
            end else if (move) begin
                r_pv    <= 1'b0;
            end
        end
    end

    // pending stage waits for the memory read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pmem  <= n_pmem;
            r_pstat <= n_pstat;
            r_pcnt  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            if (move) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_oval  <= r_pmem ? rdata : dqu_pkg::NO_VALUE;
            r_ostat <= r_pstat;
            r_ocnt  <= r_pcnt;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = OW'({r_ocnt, r_oval});
    assign o_m_tuser  = r_ostat;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ostat == dqu_pkg::ST_FULL) |-> (r_ocnt == CW'(DEPTH)))
        else $error("refused push without full count");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ostat == dqu_pkg::ST_EMPTY) |->
            (r_ocnt == '0 && r_oval == dqu_pkg::NO_VALUE))
        else $error("empty pop result malformed");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !full && (mode == dqu_pkg::MODE_PUSH_FRONT ||
                             mode == dqu_pkg::MODE_PUSH_BACK))
            |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow count");

endmodule
